// ===== sv/dda_pkg.sv =====
package dda_pkg;

   localparam logic [16:0] TRACK_BYTES         = 17'd75500;
   localparam logic [10:0] REWIND_BYTES        = 11'd1800;
   localparam logic [15:0] INSERT_BOUNCE_TICKS = 16'd32768;
   localparam logic [8:0]  BYTE_STEP           = 9'd3;
   localparam logic [8:0]  BYTE_PERIOD         = 9'd448;
   localparam logic [23:0] CRC_POLY            = 24'h010810;
   localparam logic [7:0]  GAP_MARK            = 8'h80;
   localparam logic [4:0]  STATUS_SAT          = 5'd24;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;

   localparam logic [7:0] ADDR_RELOAD_LO = 8'h20;
   localparam logic [7:0] ADDR_RELOAD_HI = 8'h21;
   localparam logic [7:0] ADDR_TIMER_CTL = 8'h22;
   localparam logic [7:0] ADDR_ENABLE    = 8'h23;
   localparam logic [7:0] ADDR_DATA_WR   = 8'h24;
   localparam logic [7:0] ADDR_DRIVE_CTL = 8'h25;
   localparam logic [7:0] ADDR_STATUS    = 8'h30;
   localparam logic [7:0] ADDR_DATA_RD   = 8'h31;
   localparam logic [7:0] ADDR_DRIVE_ST  = 8'h32;
   localparam logic [7:0] ADDR_EXT_ST    = 8'h33;

   typedef struct packed {
      logic        regs_enabled;
      logic        drive_reset;
      logic        mirror_flag;
      logic [15:0] timer_count;
      logic [15:0] timer_reload;
      logic        timer_on;
      logic        timer_repeat;
      logic        timer_irq_pending;
      logic        data_irq_pending;
      logic        drive_ready;
      logic        motor_requested;
      logic        motor_running;
      logic        write_mode;
      logic        at_track_end;
      logic        gap_skip;
      logic [16:0] position;
      logic [10:0] rewind_count;
      logic [8:0]  byte_clock;
      logic        data_irq_enable;
      logic        byte_ready;
      logic [7:0]  data_register;
      logic        crc_emit;
      logic        crc_hold;
      logic [15:0] crc_value;
      logic [4:0]  since_status_read;
      logic [15:0] since_insert;
      logic        bounce_flag;
   } dda_state_type;

   typedef struct packed {
      logic        motor_on;
      logic        mirror_horizontal;
      logic        disk_change_ack;
      logic [7:0]  disk_write_byte;
      logic        disk_write_strobe;
      logic [16:0] track_position;
      logic        irq_request;
      logic        read_claimed;
      logic [7:0]  read_data;
   } rsp_type;

   // reflected CRC-16, one byte shifted in from above the high end
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [23:0] c;
      c = {b, crc};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = c ^ CRC_POLY;
         end
         c = c >> 1;
      end
      return c[15:0];
   endfunction

endpackage

// ===== sv/disk_drive_adapter_with_timer.sv =====
// channel  dir  ports                          contents
// req      in   req_tvalid/tready/tdata/tuser  one tick, register read or write
// rsp      out  rsp_tvalid/tready/tdata        one result per item
// csr      in   csr_valid/ready/data           ignore_crc_error
//
// One item per cycle: the state update is a single pass of logic from the
// req port into the state registers, and the result lands in a two-entry
// output queue. req_tready drops only when both queue entries are full.
// Reset is synchronous and zeroes all state but at_track_end; queue entries keep data.
module disk_drive_adapter_with_timer
   import dda_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] reg_addr, [15:8] write_value, [23:16] disk_byte, [24] disk_byte_present,
   // [25] disk_inserted, [26] disk_changed, [27] write_protected, [31:28] zero
   input  logic [31:0] req_tdata,
   // [1:0] cmd
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] read_data, [8] read_claimed, [9] irq_request, [26:10] track_position,
   // [27] disk_write_strobe, [35:28] disk_write_byte, [36] disk_change_ack,
   // [37] mirror_horizontal, [38] motor_on, [39] zero
   output logic [39:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   dda_state_type state_ff, state_in, state_rst;
   logic        ignore_crc_ff;
   rsp_type     result;
   rsp_type     out0_ff, out0_in, out1_ff, out1_in;
   logic [1:0]  count_ff, count_in;

   logic [1:0]  cmd;
   logic [7:0]  reg_addr, write_value, disk_byte;
   logic        disk_byte_present, disk_inserted, disk_changed, write_protected;
   logic        push, pop;

   assign cmd               = req_tuser;
   assign reg_addr          = req_tdata[7:0];
   assign write_value       = req_tdata[15:8];
   assign disk_byte         = req_tdata[23:16];
   assign disk_byte_present = req_tdata[24];
   assign disk_inserted     = req_tdata[25];
   assign disk_changed      = req_tdata[26];
   assign write_protected   = req_tdata[27];

   assign csr_ready  = 1'b1;
   assign req_tready = (count_ff != 2'd2);
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = {1'b0, out0_ff};
   assign push       = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;

   always_comb begin
      state_rst              = '0;
      state_rst.at_track_end = 1'b1;
   end

   always_comb begin
      dda_state_type s;
      logic [7:0] rd;
      logic       claimed, strobe, ack;
      logic [7:0] wbyte;
      logic [8:0] bc;
      s       = state_ff;
      rd      = 8'd0;
      claimed = 1'b0;
      strobe  = 1'b0;
      wbyte   = 8'd0;
      ack     = 1'b0;
      bc      = 9'd0;
      case (cmd)
         CMD_TICK: begin
            if (s.regs_enabled && s.timer_on) begin
               if (s.timer_count == 16'd0) begin
                  s.timer_irq_pending = 1'b1;
                  if (s.timer_repeat) begin
                     s.timer_count = s.timer_reload;
                  end else begin
                     s.timer_on = 1'b0;
                  end
               end else begin
                  s.timer_count = s.timer_count - 16'd1;
               end
            end
            if (s.since_insert != 16'd0) begin
               s.since_insert = s.since_insert - 16'd1;
               if (s.since_insert == 16'd0) begin
                  s.since_status_read = 5'd0;
               end else if (s.since_status_read < STATUS_SAT) begin
                  s.since_status_read = s.since_status_read + 5'd1;
               end
            end
            if (disk_changed && disk_inserted) begin
               ack            = 1'b1;
               s.since_insert = INSERT_BOUNCE_TICKS;
               s.bounce_flag  = 1'b0;
               s.position     = 17'd0;
               s.at_track_end = 1'b1;
               s.drive_ready  = 1'b0;
            end
            if (s.drive_reset) begin
               s.drive_ready     = 1'b0;
               s.motor_requested = 1'b0;
            end
            if (s.motor_requested && !s.motor_running) begin
               s.motor_running = 1'b1;
            end
            bc = s.byte_clock + BYTE_STEP;
            if (bc >= BYTE_PERIOD) begin
               bc           = bc - BYTE_PERIOD;
               s.byte_ready = 1'b0;
               if (!s.motor_running) begin
                  if (s.data_irq_enable) begin
                     s.data_irq_pending = 1'b1;
                  end
               end else begin
                  if (s.at_track_end) begin
                     if (!s.motor_requested) begin
                        s.motor_running = 1'b0;
                     end
                     if (s.rewind_count == 11'd0) begin
                        s.rewind_count = REWIND_BYTES;
                     end else begin
                        s.rewind_count = s.rewind_count - 11'd1;
                        if (s.rewind_count == 11'd0) begin
                           s.at_track_end = 1'b0;
                           if (!s.write_mode) begin
                              s.drive_ready = 1'b1;
                           end
                           s.position = 17'd0;
                        end
                     end
                  end else if (disk_inserted) begin
                     if (s.write_mode) begin
                        if (s.position < TRACK_BYTES) begin
                           strobe = 1'b1;
                           if (s.crc_hold) begin
                              wbyte       = 8'd0;
                              s.crc_value = 16'd0;
                           end else begin
                              if (s.crc_emit) begin
                                 wbyte       = s.crc_value[7:0];
                                 s.crc_value = {8'd0, s.crc_value[15:8]};
                              end else begin
                                 wbyte       = s.data_register;
                                 s.crc_value = crc_feed(s.crc_value, s.data_register);
                              end
                              s.byte_ready = 1'b1;
                              if (s.data_irq_enable) begin
                                 s.data_irq_pending = 1'b1;
                              end
                           end
                        end
                     end else if (disk_byte_present) begin
                        if (s.crc_hold) begin
                           s.gap_skip = 1'b1;
                        end
                        if (s.gap_skip) begin
                           if (disk_byte == GAP_MARK) begin
                              s.gap_skip  = 1'b0;
                              s.crc_value = crc_feed(16'd0, GAP_MARK);
                           end
                        end else begin
                           s.data_register = disk_byte;
                           s.crc_value     = crc_feed(s.crc_value, disk_byte);
                           s.byte_ready    = 1'b1;
                           if (s.data_irq_enable) begin
                              s.data_irq_pending = 1'b1;
                           end
                        end
                     end
                  end
                  s.position = s.position + 17'd1;
                  if (s.position >= TRACK_BYTES) begin
                     s.at_track_end = 1'b1;
                     s.drive_ready  = 1'b0;
                  end
               end
            end
            s.byte_clock = bc;
         end
         CMD_READ: begin
            claimed = 1'b1;
            unique case (reg_addr)
               ADDR_STATUS: begin
                  rd = {s.byte_ready, s.at_track_end, 1'b0,
                        (s.crc_value != 16'd0) && !ignore_crc_ff, s.mirror_flag, 1'b0,
                        s.data_irq_pending, s.timer_irq_pending};
                  s.timer_irq_pending = 1'b0;
                  s.data_irq_pending  = 1'b0;
               end
               ADDR_DATA_RD: begin
                  rd                 = s.data_register;
                  s.byte_ready       = 1'b0;
                  s.data_irq_pending = 1'b0;
               end
               ADDR_DRIVE_ST: begin
                  rd = (disk_inserted ? 8'h00 : 8'h05)
                     | ((!s.motor_requested || !s.drive_ready) ? 8'h02 : 8'h00)
                     | (write_protected ? 8'h04 : 8'h00) | 8'h40;
                  // status bounce right after an insertion
                  if (s.since_insert != 16'd0 && s.since_status_read < STATUS_SAT) begin
                     rd            = rd | {7'd0, s.bounce_flag};
                     s.bounce_flag = !s.bounce_flag;
                  end
                  s.since_status_read = 5'd0;
               end
               ADDR_EXT_ST: begin
                  rd = 8'h80;
               end
               default: begin
                  claimed = 1'b0;
               end
            endcase
         end
         CMD_WRITE: begin
            unique case (reg_addr)
               ADDR_RELOAD_LO: begin
                  s.timer_reload[7:0] = write_value;
               end
               ADDR_RELOAD_HI: begin
                  s.timer_reload[15:8] = write_value;
               end
               ADDR_TIMER_CTL: begin
                  if (s.regs_enabled) begin
                     s.timer_repeat = write_value[0];
                     s.timer_on     = write_value[1];
                     if (write_value[1]) begin
                        s.timer_count = s.timer_reload;
                     end else begin
                        s.timer_irq_pending = 1'b0;
                     end
                  end
               end
               ADDR_ENABLE: begin
                  s.regs_enabled = write_value[0];
                  if (!write_value[0]) begin
                     s.timer_irq_pending = 1'b0;
                  end
               end
               ADDR_DATA_WR: begin
                  s.data_irq_pending = 1'b0;
                  if (s.regs_enabled) begin
                     s.data_register = write_value;
                     s.byte_ready    = 1'b0;
                  end
               end
               ADDR_DRIVE_CTL: begin
                  s.data_irq_pending = 1'b0;
                  if (s.regs_enabled) begin
                     if (!s.crc_emit && write_value[4] && !write_value[2]) begin
                        s.crc_value = crc_feed(crc_feed(s.crc_value, 8'd0), 8'd0);
                     end
                     s.drive_reset     = !write_value[0];
                     s.motor_requested = !write_value[1];
                     s.write_mode      = !write_value[2];
                     s.mirror_flag     = write_value[3];
                     s.crc_emit        = write_value[4];
                     s.crc_hold        = !write_value[6];
                     s.data_irq_enable = write_value[7];
                     s.byte_clock      = 9'd0;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
      state_in                 = s;
      result.read_data         = rd;
      result.read_claimed      = claimed;
      result.irq_request       = s.timer_irq_pending | s.data_irq_pending;
      result.track_position    = s.position;
      result.disk_write_strobe = strobe;
      result.disk_write_byte   = wbyte;
      result.disk_change_ack   = ack;
      result.mirror_horizontal = s.mirror_flag;
      result.motor_on          = s.motor_running;
   end

   always_comb begin
      out0_in  = out0_ff;
      out1_in  = out1_ff;
      count_in = count_ff;
      if (pop && !push) begin
         out0_in  = out1_ff;
         count_in = count_ff - 2'd1;
      end else if (push && !pop) begin
         if (count_ff == 2'd0) begin
            out0_in = result;
         end else begin
            out1_in = result;
         end
         count_in = count_ff + 2'd1;
      end else if (push && pop) begin
         if (count_ff == 2'd1) begin
            out0_in = result;
         end else begin
            out0_in = out1_ff;
            out1_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      out0_ff <= out0_in;
      out1_ff <= out1_in;
      if (reset) begin
         count_ff      <= 2'd0;
         ignore_crc_ff <= 1'b0;
         state_ff      <= state_rst;
      end else begin
         count_ff <= count_in;
         if (csr_valid) begin
            ignore_crc_ff <= csr_data;
         end
         if (push) begin
            state_ff <= state_in;
         end
      end
   end

endmodule
